### design/fmsd_pkg.sv
// Shared types and constants of the multi-server job dispatcher.
package fmsd_pkg;

	localparam int JOB_TYPE_W = 2;
	localparam int NUM_TYPES = 4;
	localparam int IN_TIME_W = 10;
	localparam int CNT_W = 16;
	localparam int IDLE_TOTAL_W = 32;
	localparam int OUT_DEPTH_W = 7;
	localparam int OUT_MASK_W = 8;
	localparam int OUT_IDLE_W = 4;
	localparam int IN_TDATA_W = 16;
	localparam int OUT_TDATA_W = 144;

	typedef enum logic {
		OP_ARRIVAL = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [JOB_TYPE_W-1:0] {
		JOB_A = 2'd0,
		JOB_B = 2'd1,
		JOB_C = 2'd2,
		JOB_D = 2'd3
	} job_type_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

### design/fmsd_queue.sv
// Job FIFO: circular memory with head, tail and fill count, registered head read.
module fmsd_queue #(
	parameter int DEPTH = 64,
	parameter int DW = 12,
	localparam int AW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fmsd_pkg::q_ctrl_t  ctrl,
	input  logic [DW-1:0]      wr_data,
	output logic [DW-1:0]      head_data,
	output logic [CW-1:0]      count
);
	import fmsd_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [AW-1:0] head_d;
	logic [CW-1:0] count_q;
	logic [DW-1:0] rd_q;

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head_d = ctrl.pop ? wrap_next(head_q) : head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_d;
			if (ctrl.push) begin
				tail_q <= wrap_next(tail_q);
				count_q <= count_q + 1'b1;
			end else if (ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[tail_q] <= wr_data;
		end
		rd_q <= mem[head_d];
	end

	assign head_data = rd_q;
	assign count = count_q;

endmodule

### design/fifo_multi_server_dispatcher.sv
// Top level of the multi-server job dispatcher with a bounded job FIFO.
//
// An arrival item queues one job unless the FIFO is full, passing through the arrive and done states.
// A tick item walks the servers one per cycle through a single shared dispatch and
// countdown unit, then passes to the done state. The input side is not ready while an
// item is in work. Each item returns one result, which is held in an output register
// until it is taken, and the block accepts the next item meanwhile. The FIFO head is
// read from a memory with a registered port.
module fifo_multi_server_dispatcher #(
	parameter int NUM_SERVERS = 8,
	parameter int QUEUE_DEPTH = 64,
	parameter int TIME_WIDTH = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// job_type [1:0], processing_time [11:2], zero fill
	input  logic [fmsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// opcode [0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status, queue_depth, dispatched_mask, completed_mask, idle_servers,
	// arrived_of_type, completed_a, completed_b, completed_c, completed_d,
	// total_idle_time, zero fill
	output logic [fmsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import fmsd_pkg::*;

	localparam int SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(NUM_SERVERS + 1);
	localparam int PW = (TIME_WIDTH > IN_TIME_W) ? TIME_WIDTH : IN_TIME_W;
	localparam int EW = JOB_TYPE_W + TIME_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ARRIVE,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t state_q;
	opcode_t op_q;
	logic [JOB_TYPE_W-1:0] jt_q;
	logic [TIME_WIDTH-1:0] pt_q;
	logic [SW-1:0] srv_q;
	logic status_q;
	logic [NUM_SERVERS-1:0] dmask_q;
	logic [NUM_SERVERS-1:0] cmask_q;
	logic [IW-1:0] idle_n_q;
	logic [CNT_W-1:0] arr_q;

	logic [NUM_SERVERS-1:0] busy_q;
	logic [TIME_WIDTH-1:0] rem_q [NUM_SERVERS];
	logic [JOB_TYPE_W-1:0] stype_q [NUM_SERVERS];
	logic [CNT_W-1:0] arrivals_q [NUM_TYPES];
	logic [CNT_W-1:0] completions_q [NUM_TYPES];
	logic [IDLE_TOTAL_W-1:0] idle_total_q;

	logic out_valid_q;
	logic out_status_q;
	logic [OUT_DEPTH_W-1:0] out_depth_q;
	logic [OUT_MASK_W-1:0] out_dmask_q;
	logic [OUT_MASK_W-1:0] out_cmask_q;
	logic [OUT_IDLE_W-1:0] out_idle_q;
	logic [CNT_W-1:0] out_arr_q;
	logic [CNT_W-1:0] out_ca_q;
	logic [CNT_W-1:0] out_cb_q;
	logic [CNT_W-1:0] out_cc_q;
	logic [CNT_W-1:0] out_cd_q;
	logic [IDLE_TOTAL_W-1:0] out_idle_total_q;

	q_ctrl_t q_ctrl;
	logic [EW-1:0] q_head;
	logic [QCW-1:0] q_count;
	logic q_full;
	logic q_empty;

	logic [PW-1:0] in_time_ext;
	logic [PW-1:0] time_max_ext;
	logic [PW-1:0] in_time_sat;
	logic [TIME_WIDTH-1:0] in_time;

	logic [JOB_TYPE_W-1:0] head_type;
	logic [TIME_WIDTH-1:0] head_time;
	logic dispatch;
	logic busy_eff;
	logic [TIME_WIDTH-1:0] rem_eff;
	logic [TIME_WIDTH-1:0] rem_next;
	logic [JOB_TYPE_W-1:0] type_eff;
	logic finish;
	logic out_free;
	logic out_load;

	logic [QCW+OUT_DEPTH_W-1:0] depth_ext;
	logic [NUM_SERVERS+OUT_MASK_W-1:0] dmask_ext;
	logic [NUM_SERVERS+OUT_MASK_W-1:0] cmask_ext;
	logic [IW+OUT_IDLE_W-1:0] idle_ext;

	assign in_time_ext = PW'(s_axis_tdata[JOB_TYPE_W +: IN_TIME_W]);
	assign time_max_ext = PW'({TIME_WIDTH{1'b1}});
	assign in_time_sat = (in_time_ext > time_max_ext) ? time_max_ext : in_time_ext;
	assign in_time = (in_time_sat == '0) ? TIME_WIDTH'(1) : in_time_sat[TIME_WIDTH-1:0];

	assign q_full = (q_count >= QCW'(QUEUE_DEPTH));
	assign q_empty = (q_count == '0);
	assign head_type = q_head[TIME_WIDTH +: JOB_TYPE_W];
	assign head_time = q_head[TIME_WIDTH-1:0];

	assign dispatch = (state_q == ST_WALK) && !busy_q[srv_q] && !q_empty;
	assign busy_eff = busy_q[srv_q] || dispatch;
	assign rem_eff = dispatch ? head_time : rem_q[srv_q];
	assign type_eff = dispatch ? head_type : stype_q[srv_q];
	assign rem_next = (rem_eff != '0) ? rem_eff - 1'b1 : rem_eff;
	assign finish = busy_eff && (rem_next == '0);

	assign q_ctrl.push = (state_q == ST_ARRIVE) && !q_full;
	assign q_ctrl.pop = dispatch;

	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = (state_q == ST_DONE) && out_free;
	assign s_axis_tready = (state_q == ST_IDLE);

	assign depth_ext = {{OUT_DEPTH_W{1'b0}}, q_count};
	assign dmask_ext = {{OUT_MASK_W{1'b0}}, dmask_q};
	assign cmask_ext = {{OUT_MASK_W{1'b0}}, cmask_q};
	assign idle_ext = {{OUT_IDLE_W{1'b0}}, idle_n_q};

	fmsd_queue #(
		.DEPTH(QUEUE_DEPTH),
		.DW(EW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(q_ctrl),
		.wr_data({jt_q, pt_q}),
		.head_data(q_head),
		.count(q_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			srv_q <= '0;
			busy_q <= '0;
			idle_total_q <= '0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < NUM_SERVERS; s++) begin
				rem_q[s] <= '0;
				stype_q[s] <= '0;
			end
			for (int t = 0; t < NUM_TYPES; t++) begin
				arrivals_q[t] <= '0;
				completions_q[t] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q <= opcode_t'(s_axis_tuser);
						jt_q <= s_axis_tdata[JOB_TYPE_W-1:0];
						pt_q <= in_time;
						srv_q <= '0;
						status_q <= 1'b0;
						dmask_q <= '0;
						cmask_q <= '0;
						idle_n_q <= '0;
						arr_q <= '0;
						state_q <= (opcode_t'(s_axis_tuser) == OP_TICK) ? ST_WALK : ST_ARRIVE;
					end
				end
				ST_ARRIVE: begin
					arrivals_q[jt_q] <= sat_inc16(arrivals_q[jt_q]);
					arr_q <= sat_inc16(arrivals_q[jt_q]);
					status_q <= q_full;
					state_q <= ST_DONE;
				end
				ST_WALK: begin
					if (dispatch) begin
						dmask_q[srv_q] <= 1'b1;
						stype_q[srv_q] <= head_type;
					end else if (!busy_q[srv_q]) begin
						idle_n_q <= idle_n_q + 1'b1;
						if (idle_total_q != {IDLE_TOTAL_W{1'b1}}) begin
							idle_total_q <= idle_total_q + 1'b1;
						end
					end
					if (busy_eff) begin
						rem_q[srv_q] <= rem_next;
						busy_q[srv_q] <= !finish;
					end
					if (finish) begin
						cmask_q[srv_q] <= 1'b1;
						completions_q[type_eff] <= sat_inc16(completions_q[type_eff]);
					end
					if (srv_q == SW'(NUM_SERVERS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						srv_q <= srv_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_depth_q <= depth_ext[OUT_DEPTH_W-1:0];
						out_dmask_q <= dmask_ext[OUT_MASK_W-1:0];
						out_cmask_q <= cmask_ext[OUT_MASK_W-1:0];
						out_idle_q <= idle_ext[OUT_IDLE_W-1:0];
						out_arr_q <= (op_q == OP_ARRIVAL) ? arr_q : '0;
						out_ca_q <= completions_q[JOB_A];
						out_cb_q <= completions_q[JOB_B];
						out_cc_q <= completions_q[JOB_C];
						out_cd_q <= completions_q[JOB_D];
						out_idle_total_q <= idle_total_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {
		4'b0,
		out_idle_total_q,
		out_cd_q,
		out_cc_q,
		out_cb_q,
		out_ca_q,
		out_arr_q,
		out_idle_q,
		out_cmask_q,
		out_dmask_q,
		out_depth_q,
		out_status_q
	};

endmodule
